// ===== hw/rtl/fdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fdsa_pkg
// Shared constants, word codes and types for the Forth data stack and ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fdsa_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int CELL_W      = 32;

    // Word codes carried in the kind field.
    localparam logic [4:0] K_LIT    = 5'd0;
    localparam logic [4:0] K_ADD    = 5'd1;
    localparam logic [4:0] K_SUB    = 5'd2;
    localparam logic [4:0] K_MUL    = 5'd3;
    localparam logic [4:0] K_DIV    = 5'd4;
    localparam logic [4:0] K_MOD    = 5'd5;
    localparam logic [4:0] K_EQ     = 5'd6;
    localparam logic [4:0] K_GT     = 5'd7;
    localparam logic [4:0] K_LT     = 5'd8;
    localparam logic [4:0] K_AND    = 5'd9;
    localparam logic [4:0] K_OR     = 5'd10;
    localparam logic [4:0] K_INVERT = 5'd11;
    localparam logic [4:0] K_DOT    = 5'd12;
    localparam logic [4:0] K_EMIT   = 5'd13;
    localparam logic [4:0] K_DUP    = 5'd14;
    localparam logic [4:0] K_DROP   = 5'd15;
    localparam logic [4:0] K_SWAP   = 5'd16;
    localparam logic [4:0] K_OVER   = 5'd17;
    localparam logic [4:0] K_ROT    = 5'd18;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    typedef struct packed {
        logic              done;
        logic [CELL_W-1:0] quo;
        logic [CELL_W-1:0] rem;
    } div_res_t;

    // Number of cells a word needs on the stack.
    function automatic logic [1:0] need_of(input logic [4:0] k);
        logic [1:0] n;
        n = 2'd0;
        case (k) inside
            [K_ADD:K_OR], K_SWAP, K_OVER: n = 2'd2;
            [K_INVERT:K_DROP]:            n = 2'd1;
            K_ROT:                        n = 2'd3;
            default:                      n = 2'd0;
        endcase
        return n;
    endfunction

    // Words that add one cell.
    function automatic logic grows(input logic [4:0] k);
        logic g;
        g = 1'b0;
        case (k) inside
            K_LIT, K_DUP, K_OVER: g = 1'b1;
            default:              g = 1'b0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fdsa_ram.sv =====
// ----------------------------------------------------------------------------
// fdsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fdsa_div.sv =====
// ----------------------------------------------------------------------------
// fdsa_div
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsa_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [fdsa_pkg::CELL_W-1:0]  num,
    input  wire logic [fdsa_pkg::CELL_W-1:0]  den,
    output fdsa_pkg::div_res_t                res
);

    localparam int W = fdsa_pkg::CELL_W;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [W:0]           rem_reg, rem_next;
    logic [W-1:0]         quo_reg, quo_next;
    logic [W-1:0]         den_reg, den_next;
    logic                 nneg_reg, nneg_next;
    logic                 qneg_reg, qneg_next;
    logic [W:0]           shifted;
    logic [W:0]           diff;

    assign shifted = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        nneg_next = nneg_reg;
        qneg_next = qneg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = '0;
            quo_next  = num[W-1] ? (W'(0) - num) : num;
            den_next  = den[W-1] ? (W'(0) - den) : den;
            nneg_next = num[W-1];
            qneg_next = num[W-1] ^ den[W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        nneg_reg <= nneg_next;
        qneg_reg <= qneg_next;
    end

    assign res.done = done_reg;
    assign res.quo  = qneg_reg ? (W'(0) - quo_reg) : quo_reg;
    assign res.rem  = nneg_reg ? (W'(0) - rem_reg[W-1:0]) : rem_reg[W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/fdsa_alu.sv =====
// ----------------------------------------------------------------------------
// fdsa_alu
// Combinational arithmetic, compare and logic words (division excluded).
// ----------------------------------------------------------------------------
`default_nettype none

module fdsa_alu (
    input  wire logic [4:0]                  kind,
    input  wire logic [fdsa_pkg::CELL_W-1:0] a,
    input  wire logic [fdsa_pkg::CELL_W-1:0] b,
    output logic [fdsa_pkg::CELL_W-1:0]      r
);

    localparam int W = fdsa_pkg::CELL_W;

    logic [W-1:0] prod;

    // Only the low half of the product is kept, so products wrap.
    assign prod = b * a;

    always_comb
    begin
        r = '0;
        case (kind)
            fdsa_pkg::K_ADD:    r = b + a;
            fdsa_pkg::K_SUB:    r = b - a;
            fdsa_pkg::K_MUL:    r = prod;
            fdsa_pkg::K_EQ:     r = W'(b == a);
            fdsa_pkg::K_GT:     r = W'($signed(a) < $signed(b));
            fdsa_pkg::K_LT:     r = W'($signed(b) < $signed(a));
            fdsa_pkg::K_AND:    r = W'((a != '0) && (b != '0));
            fdsa_pkg::K_OR:     r = W'((a != '0) || (b != '0));
            fdsa_pkg::K_INVERT: r = W'(a == '0);
            default:            r = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/forth_data_stack_alu.sv =====
// ----------------------------------------------------------------------------
// forth_data_stack_alu
// Forth data stack held in a synchronous RAM, with a sequencer and an ALU.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   ----------------------------------------
//   input     in_valid / in_stall  kind, literal
//   result    res_valid/res_stall  status, out_valid, out_value,
//                                  out_is_char, top_value, depth
//
// From acceptance, a word that changes nothing (underflow, overflow, divide
// by zero, unknown code) goes straight to the output register. Other words
// read their cells from the RAM, which takes one read and one write per
// cycle; / and mod then wait on the divider, which resolves one quotient bit
// per cycle. Cells are written back (none for . emit and drop) and the result
// goes to the output register; the next request is taken in the cycle after.
// Reset clears the cell count and the control state; the RAM is not cleared,
// as cells at or above the count are never used.
// A stall on the result side holds the output register; the next request may
// still be taken and worked on until its own result is ready, and it then
// waits in the hand-off state for as long as the output stays stalled.
//
`default_nettype none

module forth_data_stack_alu (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [4:0]                   kind,
    input  wire logic signed [31:0]           literal,
    output logic                              res_valid,
    input  wire logic                         res_stall,
    output logic [1:0]                        status,
    output logic                              out_valid,
    output logic signed [31:0]                out_value,
    output logic                              out_is_char,
    output logic signed [31:0]                top_value,
    output logic [8:0]                        depth
);

    localparam int W  = fdsa_pkg::CELL_W;
    localparam int AW = fdsa_pkg::ADDR_W;
    localparam int CW = fdsa_pkg::CNT_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RB   = 3'd1;  // second cell arriving from RAM
    localparam logic [2:0] S_RC   = 3'd2;  // third cell arriving from RAM
    localparam logic [2:0] S_EX   = 3'd3;  // compute, then plan the writes or start the divider
    localparam logic [2:0] S_DV   = 3'd4;  // waiting on the divider
    localparam logic [2:0] S_WR   = 3'd5;  // write-back, one cell per cycle
    localparam logic [2:0] S_DN   = 3'd6;  // hand the result to the output

    logic [2:0]     state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]   top_reg, top_next;
    logic [4:0]     kind_reg, kind_next;
    logic [W-1:0]   lit_reg, lit_next;
    logic [W-1:0]   b_reg, b_next;
    logic [W-1:0]   c_reg, c_next;
    logic [1:0]     st_reg, st_next;
    logic           ov_reg, ov_next;
    logic [W-1:0]   oval_reg, oval_next;
    logic           och_reg, och_next;
    logic [1:0]     wn_reg, wn_next;
    logic [1:0]     wi_reg, wi_next;
    logic [AW-1:0]  wa_reg [3];
    logic [AW-1:0]  wa_next [3];
    logic [W-1:0]   wd_reg [3];
    logic [W-1:0]   wd_next [3];

    logic           rv_reg, rv_next;
    logic [1:0]     rs_status_reg, rs_status_next;
    logic           rs_ov_reg, rs_ov_next;
    logic [W-1:0]   rs_oval_reg, rs_oval_next;
    logic           rs_och_reg, rs_och_next;
    logic [W-1:0]   rs_top_reg, rs_top_next;
    logic [8:0]     rs_depth_reg, rs_depth_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [W-1:0]   ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [W-1:0]   ram_rdata;

    logic           div_start;
    fdsa_pkg::div_res_t div_res;
    logic [W-1:0]   alu_r;

    logic [AW-1:0]  base;
    logic [W-1:0]   r_val;
    logic           is_divkind;
    logic           do_plan;

    fdsa_ram #(
        .WIDTH (W),
        .DEPTH (fdsa_pkg::STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fdsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (b_reg),
        .den   (top_reg),
        .res   (div_res)
    );

    fdsa_alu u_alu (
        .kind (kind_reg),
        .a    (top_reg),
        .b    (b_reg),
        .r    (alu_r)
    );

    // The top cell lives in top_reg and is also written through to the RAM,
    // so the RAM always holds every cell below the count.
    assign base       = cnt_reg[AW-1:0];
    assign is_divkind = (kind_reg == fdsa_pkg::K_DIV) || (kind_reg == fdsa_pkg::K_MOD);
    assign r_val      = (state_reg == S_DV)
                        ? ((kind_reg == fdsa_pkg::K_DIV) ? div_res.quo : div_res.rem)
                        : alu_r;
    assign do_plan    = ((state_reg == S_EX) && !is_divkind)
                        || ((state_reg == S_DV) && div_res.done);

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        top_next       = top_reg;
        kind_next      = kind_reg;
        lit_next       = lit_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        st_next        = st_reg;
        ov_next        = ov_reg;
        oval_next      = oval_reg;
        och_next       = och_reg;
        wn_next        = wn_reg;
        wi_next        = wi_reg;
        wa_next        = wa_reg;
        wd_next        = wd_reg;
        rv_next        = rv_reg;
        rs_status_next = rs_status_reg;
        rs_ov_next     = rs_ov_reg;
        rs_oval_next   = rs_oval_reg;
        rs_och_next    = rs_och_reg;
        rs_top_next    = rs_top_reg;
        rs_depth_next  = rs_depth_reg;
        ram_we         = 1'b0;
        ram_waddr      = wa_reg[wi_reg];
        ram_wdata      = wd_reg[wi_reg];
        ram_re         = 1'b0;
        ram_raddr      = base - AW'(2);
        div_start      = 1'b0;

        if (rv_reg && !res_stall)
        begin
            rv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    lit_next  = literal;
                    st_next   = fdsa_pkg::ST_OK;
                    ov_next   = 1'b0;
                    oval_next = '0;
                    och_next  = 1'b0;
                    ram_re    = 1'b1;
                    if (kind > fdsa_pkg::K_ROT)
                    begin
                        state_next = S_DN;
                    end
                    else if (cnt_reg < CW'(fdsa_pkg::need_of(kind)))
                    begin
                        st_next    = fdsa_pkg::ST_UNDER;
                        state_next = S_DN;
                    end
                    else if (fdsa_pkg::grows(kind) && (cnt_reg >= CW'(fdsa_pkg::STACK_DEPTH)))
                    begin
                        st_next    = fdsa_pkg::ST_OVER;
                        state_next = S_DN;
                    end
                    else if (((kind == fdsa_pkg::K_DIV) || (kind == fdsa_pkg::K_MOD))
                             && (top_reg == '0))
                    begin
                        st_next    = fdsa_pkg::ST_DIVZ;
                        state_next = S_DN;
                    end
                    else
                    begin
                        state_next = S_RB;
                    end
                end
            end
            S_RB:
            begin
                b_next = ram_rdata;
                if (kind_reg == fdsa_pkg::K_ROT)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = base - AW'(3);
                    state_next = S_RC;
                end
                else
                begin
                    state_next = S_EX;
                end
            end
            S_RC:
            begin
                c_next     = ram_rdata;
                state_next = S_EX;
            end
            S_EX:
            begin
                if (is_divkind)
                begin
                    div_start  = 1'b1;
                    state_next = S_DV;
                end
            end
            S_DV:
            begin
                // Leaves through the write plan below once the divider is done.
            end
            S_WR:
            begin
                ram_we  = 1'b1;
                wi_next = wi_reg + 2'd1;
                if (wi_reg == (wn_reg - 2'd1))
                begin
                    state_next = S_DN;
                end
            end
            S_DN:
            begin
                if (!rv_reg || !res_stall)
                begin
                    rv_next        = 1'b1;
                    rs_status_next = st_reg;
                    rs_ov_next     = ov_reg;
                    rs_oval_next   = oval_reg;
                    rs_och_next    = och_reg;
                    rs_top_next    = (cnt_reg == '0) ? '0 : top_reg;
                    rs_depth_next  = 9'(cnt_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Write plan: decide the new count, the new top and the cells that
        // go back to the RAM, then run the write-back when there is one.
        if (do_plan)
        begin
            wi_next    = 2'd0;
            wn_next    = 2'd1;
            state_next = S_WR;
            case (kind_reg) inside
                [fdsa_pkg::K_ADD:fdsa_pkg::K_OR]:
                begin
                    wa_next[0] = base - AW'(2);
                    wd_next[0] = r_val;
                    top_next   = r_val;
                    cnt_next   = cnt_reg - CW'(1);
                end
                fdsa_pkg::K_LIT:
                begin
                    wa_next[0] = base;
                    wd_next[0] = lit_reg;
                    top_next   = lit_reg;
                    cnt_next   = cnt_reg + CW'(1);
                end
                fdsa_pkg::K_INVERT:
                begin
                    wa_next[0] = base - AW'(1);
                    wd_next[0] = r_val;
                    top_next   = r_val;
                end
                fdsa_pkg::K_DOT, fdsa_pkg::K_EMIT:
                begin
                    ov_next    = 1'b1;
                    oval_next  = top_reg;
                    och_next   = (kind_reg == fdsa_pkg::K_EMIT);
                    top_next   = b_reg;
                    cnt_next   = cnt_reg - CW'(1);
                    wn_next    = 2'd0;
                    state_next = S_DN;
                end
                fdsa_pkg::K_DUP:
                begin
                    wa_next[0] = base;
                    wd_next[0] = top_reg;
                    cnt_next   = cnt_reg + CW'(1);
                end
                fdsa_pkg::K_DROP:
                begin
                    top_next   = b_reg;
                    cnt_next   = cnt_reg - CW'(1);
                    wn_next    = 2'd0;
                    state_next = S_DN;
                end
                fdsa_pkg::K_SWAP:
                begin
                    wn_next    = 2'd2;
                    wa_next[0] = base - AW'(1);
                    wd_next[0] = b_reg;
                    wa_next[1] = base - AW'(2);
                    wd_next[1] = top_reg;
                    top_next   = b_reg;
                end
                fdsa_pkg::K_OVER:
                begin
                    wa_next[0] = base;
                    wd_next[0] = b_reg;
                    top_next   = b_reg;
                    cnt_next   = cnt_reg + CW'(1);
                end
                fdsa_pkg::K_ROT:
                begin
                    wn_next    = 2'd3;
                    wa_next[0] = base - AW'(3);
                    wd_next[0] = b_reg;
                    wa_next[1] = base - AW'(2);
                    wd_next[1] = top_reg;
                    wa_next[2] = base - AW'(1);
                    wd_next[2] = c_reg;
                    top_next   = c_reg;
                end
                default:
                begin
                    wn_next    = 2'd0;
                    state_next = S_DN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
            wn_reg    <= 2'd0;
            wi_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= rv_next;
            wn_reg    <= wn_next;
            wi_reg    <= wi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        kind_reg      <= kind_next;
        lit_reg       <= lit_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        st_reg        <= st_next;
        ov_reg        <= ov_next;
        oval_reg      <= oval_next;
        och_reg       <= och_next;
        wa_reg        <= wa_next;
        wd_reg        <= wd_next;
        rs_status_reg <= rs_status_next;
        rs_ov_reg     <= rs_ov_next;
        rs_oval_reg   <= rs_oval_next;
        rs_och_reg    <= rs_och_next;
        rs_top_reg    <= rs_top_next;
        rs_depth_reg  <= rs_depth_next;
    end

    assign res_valid   = rv_reg;
    assign status      = rs_status_reg;
    assign out_valid   = rs_ov_reg;
    assign out_value   = rs_oval_reg;
    assign out_is_char = rs_och_reg;
    assign top_value   = rs_top_reg;
    assign depth       = rs_depth_reg;

    // The cell count never exceeds the stack size.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(fdsa_pkg::STACK_DEPTH))
        else $error("cell count above stack size");

    // A printed value only comes with a good status.
    a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid) |-> (status == fdsa_pkg::ST_OK))
        else $error("printed value with bad status");

    // An empty stack reports a zero top cell.
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (depth == 9'd0)) |-> (top_value == '0))
        else $error("nonzero top on empty stack");

    // The divider is never started with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (top_reg != '0))
        else $error("divider started with zero divisor");

    // The RAM is written only during write-back.
    a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_WR) && (wn_reg != 2'd0))
        else $error("RAM write outside write-back");

endmodule

`default_nettype wire

// ===== sim/forth_data_stack_alu_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_data_stack_alu_tb
// Drives Forth words into the data stack and ALU with random gaps and result
// stalls, and checks every result against a stack model kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module forth_data_stack_alu_tb;

    // One request as the sender presents it.
    typedef struct {
        logic [4:0]  kind;
        logic [31:0] literal;
    } word_req_t;

    // One result as the block presents it.
    typedef struct {
        logic [1:0]  status;
        logic        out_valid;
        logic [31:0] out_value;
        logic        out_is_char;
        logic [31:0] top_value;
        logic [8:0]  depth;
    } word_res_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [4:0]        kind;
    logic signed [31:0] literal;
    logic              res_valid;
    logic              res_stall;
    logic [1:0]        status;
    logic              out_valid;
    logic signed [31:0] out_value;
    logic              out_is_char;
    logic signed [31:0] top_value;
    logic [8:0]        depth;

    forth_data_stack_alu u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .literal     (literal),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .status      (status),
        .out_valid   (out_valid),
        .out_value   (out_value),
        .out_is_char (out_is_char),
        .top_value   (top_value),
        .depth       (depth)
    );

    // The bench keeps its own copy of the stack. Index 0 is the bottom cell.
    logic [31:0] model_cells [fdsa_pkg::STACK_DEPTH];
    int          model_count;

    word_req_t   pending_words [$];
    word_res_t   expected_results [$];
    int          mismatches;
    int          accepted_words;
    int          send_gap;
    int          stall_left;

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Stack model. Returns the result that one accepted word should produce
    // and updates the bench's stack copy accordingly.
    // ------------------------------------------------------------------------
    function automatic logic [31:0] cell_from_top(int pos);
        return model_cells[model_count - 1 - pos];
    endfunction

    function automatic logic [31:0] abs32(logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    function automatic word_res_t run_word(word_req_t w);
        word_res_t   r;
        int          need;
        bit          grows_stack;
        logic [31:0] a, b, c, v, q;
        r = '{default: '0};
        need = 0;
        if (w.kind >= fdsa_pkg::K_ADD && w.kind <= fdsa_pkg::K_OR) need = 2;
        else if (w.kind >= fdsa_pkg::K_INVERT && w.kind <= fdsa_pkg::K_DROP) need = 1;
        else if (w.kind == fdsa_pkg::K_SWAP || w.kind == fdsa_pkg::K_OVER) need = 2;
        else if (w.kind == fdsa_pkg::K_ROT) need = 3;
        grows_stack = (w.kind == fdsa_pkg::K_LIT || w.kind == fdsa_pkg::K_DUP
                       || w.kind == fdsa_pkg::K_OVER);
        a = (need >= 1 && model_count >= 1) ? cell_from_top(0) : '0;
        b = (need >= 2 && model_count >= 2) ? cell_from_top(1) : '0;
        c = (need >= 3 && model_count >= 3) ? cell_from_top(2) : '0;
        if (w.kind > fdsa_pkg::K_ROT) begin
            // Unknown words leave everything alone.
        end else if (model_count < need) begin
            r.status = fdsa_pkg::ST_UNDER;
        end else if (grows_stack && model_count >= fdsa_pkg::STACK_DEPTH) begin
            r.status = fdsa_pkg::ST_OVER;
        end else if ((w.kind == fdsa_pkg::K_DIV || w.kind == fdsa_pkg::K_MOD) && a == 0) begin
            r.status = fdsa_pkg::ST_DIVZ;
        end else if (w.kind >= fdsa_pkg::K_ADD && w.kind <= fdsa_pkg::K_OR) begin
            case (w.kind)
                fdsa_pkg::K_ADD: v = b + a;
                fdsa_pkg::K_SUB: v = b - a;
                fdsa_pkg::K_MUL: v = b * a;
                fdsa_pkg::K_DIV:
                begin
                    q = abs32(b) / abs32(a);
                    v = (a[31] ^ b[31]) ? -q : q;
                end
                fdsa_pkg::K_MOD:
                begin
                    q = abs32(b) % abs32(a);
                    v = b[31] ? -q : q;
                end
                fdsa_pkg::K_EQ:  v = 32'(b == a);
                fdsa_pkg::K_GT:  v = 32'($signed(b) > $signed(a));
                fdsa_pkg::K_LT:  v = 32'($signed(b) < $signed(a));
                fdsa_pkg::K_AND: v = 32'(a != 0 && b != 0);
                default:         v = 32'(a != 0 || b != 0);
            endcase
            model_count--;
            model_cells[model_count - 1] = v;
        end else begin
            case (w.kind)
                fdsa_pkg::K_LIT:
                begin
                    model_cells[model_count] = w.literal;
                    model_count++;
                end
                fdsa_pkg::K_INVERT: model_cells[model_count - 1] = 32'(a == 0);
                fdsa_pkg::K_DOT, fdsa_pkg::K_EMIT:
                begin
                    model_count--;
                    r.out_valid   = 1'b1;
                    r.out_value   = a;
                    r.out_is_char = (w.kind == fdsa_pkg::K_EMIT);
                end
                fdsa_pkg::K_DUP:
                begin
                    model_cells[model_count] = a;
                    model_count++;
                end
                fdsa_pkg::K_DROP: model_count--;
                fdsa_pkg::K_SWAP:
                begin
                    model_cells[model_count - 1] = b;
                    model_cells[model_count - 2] = a;
                end
                fdsa_pkg::K_OVER:
                begin
                    model_cells[model_count] = b;
                    model_count++;
                end
                default:
                begin
                    // rot brings the third cell to the top.
                    model_cells[model_count - 3] = b;
                    model_cells[model_count - 2] = a;
                    model_cells[model_count - 1] = c;
                end
            endcase
        end
        r.top_value = (model_count > 0) ? cell_from_top(0) : '0;
        r.depth     = model_count[8:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_word(logic [4:0] k, logic [31:0] lit);
        word_req_t w;
        w.kind    = k;
        w.literal = lit;
        pending_words.push_back(w);
    endtask

    // Literals lean toward the corners so that wrap, sign and zero cases
    // come up often, with plain random values in between.
    function automatic logic [31:0] pick_literal();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return 32'd1;
            5: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 accepted_words, field, got, want);
        mismatches++;
    endtask

    // Waits until every queued word has been sent and every result checked.
    // Sampling at the falling edge sees the settled driver outputs.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: takes words from the pending queue, holding each until it is
    // accepted, then waits a random gap. A request stays valid across back to
    // back words without dropping, so valid sees one assignment per edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            kind     <= '0;
            literal  <= '0;
            send_gap <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(run_word('{kind, literal}));
            end
            if (in_valid && in_stall) begin
                // Hold the stalled request as it is.
            end else if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_words.size() > 0) begin
                in_valid <= 1'b1;
                kind     <= pending_words[0].kind;
                literal  <= pending_words[0].literal;
                void'(pending_words.pop_front());
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stalls the result side at random and checks every accepted
    // result against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        word_res_t want;
        if (!rst_n) begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (res_valid && !res_stall) begin
                accepted_words++;
                if (expected_results.size() == 0) begin
                    $display("unexpected result with nothing outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (out_valid !== want.out_valid)
                        report_mismatch("out_valid", 32'(out_valid), 32'(want.out_valid));
                    if (out_value !== want.out_value)
                        report_mismatch("out_value", out_value, want.out_value);
                    if (out_is_char !== want.out_is_char)
                        report_mismatch("out_is_char", 32'(out_is_char),
                                        32'(want.out_is_char));
                    if (top_value !== want.top_value)
                        report_mismatch("top_value", top_value, want.top_value);
                    if (depth !== want.depth)
                        report_mismatch("depth", 32'(depth), 32'(want.depth));
                end
                // Draw a new stall length for the next result.
                stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                res_stall  <= 1'b0;
            end else if (stall_left > 0) begin
                res_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        int k;
        clk            = 1'b0;
        rst_n          = 1'b0;
        mismatches     = 0;
        accepted_words = 0;
        model_count    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: underflow on an empty stack for every word that needs a cell.
        for (k = fdsa_pkg::K_ADD; k <= fdsa_pkg::K_ROT; k++) queue_word(k[4:0], 32'd0);
        // Unknown word codes, including the all-ones code.
        queue_word(5'd19, 32'd0);
        queue_word(5'd31, 32'hffff_ffff);
        // Most negative by minus one, then divide by zero.
        queue_word(fdsa_pkg::K_LIT, 32'h8000_0000);
        queue_word(fdsa_pkg::K_LIT, 32'hffff_ffff);
        queue_word(fdsa_pkg::K_OVER, 32'd0);
        queue_word(fdsa_pkg::K_OVER, 32'd0);
        queue_word(fdsa_pkg::K_DIV, 32'd0);
        queue_word(fdsa_pkg::K_DOT, 32'd0);
        queue_word(fdsa_pkg::K_MOD, 32'd0);
        queue_word(fdsa_pkg::K_EMIT, 32'd0);
        queue_word(fdsa_pkg::K_LIT, 32'h7fff_ffff);
        queue_word(fdsa_pkg::K_LIT, 32'd0);
        queue_word(fdsa_pkg::K_DIV, 32'd0);
        queue_word(fdsa_pkg::K_MOD, 32'd0);
        queue_word(fdsa_pkg::K_ROT, 32'd0);

        // Pause until the directed part has fully drained.
        wait_drained();

        // Fill the stack to the top, hit overflow with every growing word,
        // then drain with drops past the bottom.
        while (pending_words.size() < fdsa_pkg::STACK_DEPTH)
            queue_word(fdsa_pkg::K_LIT, $urandom);
        queue_word(fdsa_pkg::K_LIT, 32'd5);
        queue_word(fdsa_pkg::K_DUP, 32'd0);
        queue_word(fdsa_pkg::K_OVER, 32'd0);
        queue_word(fdsa_pkg::K_DOT, 32'd0);
        queue_word(fdsa_pkg::K_DUP, 32'd0);
        for (n = 0; n < fdsa_pkg::STACK_DEPTH + 2; n++) queue_word(fdsa_pkg::K_DROP, 32'd0);

        // Random part: mostly words that act on a shallow stack, with a push
        // bias so that binary words rarely underflow, plus some noise.
        for (n = 0; n < 1250; n++) begin
            if ($urandom_range(0, 99) < 35) k = fdsa_pkg::K_LIT;
            else if ($urandom_range(0, 49) == 0) k = $urandom_range(19, 31);
            else k = $urandom_range(fdsa_pkg::K_ADD, fdsa_pkg::K_ROT);
            queue_word(k[4:0], pick_literal());
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog well above the slowest run: about 1800 words, each with its
    // work, its random send gap and its random result stall.
    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
